// File: hdl/cae_pkg.sv
// Package for the clause activity eviction block: sizes, codes and transaction types.
// Used by every module in hdl/; depends on nothing else.
`timescale 1ns / 1ps

package cae_pkg;

  localparam int TABLE_DEPTH   = 64;
  localparam int LIMIT_EXP     = 62;
  localparam int RESCALE_SHIFT = 40;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = 7;

  localparam logic [63:0] LIMIT_VAL = 64'(1) << LIMIT_EXP;
  localparam logic [63:0] ONE_Q32   = 64'(1) << 32;

  typedef enum logic [2:0] {
    ACT_INSERT = 3'd0,
    ACT_BUMP   = 3'd1,
    ACT_LOCK   = 3'd2,
    ACT_SETINC = 3'd3,
    ACT_DELETE = 3'd4,
    ACT_QUERY  = 3'd5
  } act_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_OP, ST_RESC, ST_DIV1, ST_WAIT1, ST_P1, ST_DIV2, ST_WAIT2, ST_P2, ST_OUT
  } state_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [5:0]  entry;
    logic [63:0] value;
    logic        locked;
  } in_t;

  typedef struct packed {
    logic             valid_res;
    logic [63:0]      activity;
    logic             lock_state;
    logic             rescaled;
    logic [CNT_W-1:0] deleted_count;
    logic [CNT_W-1:0] live_count;
  } out_t;

  typedef struct packed {
    logic [63:0] act;
    logic        vld;
    logic        lck;
  } cell_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

// File: hdl/cae_cell.sv
// One slot of the rotating activity ring: activity, valid and lock bits.
// Depends on cae_pkg.
`timescale 1ns / 1ps

module cae_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  cae_pkg::cell_t d_i,
  output cae_pkg::cell_t q_o
);
  import cae_pkg::*;

  logic [63:0] act_q;
  logic        vld_q, lck_q;

  // Activity holds no reset; it is only read while the valid bit is set.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      act_q <= d_i.act;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      lck_q <= 1'b0;
    end else if (shift_i) begin
      vld_q <= d_i.vld;
      lck_q <= d_i.lck;
    end
  end

  assign q_o = '{act: act_q, vld: vld_q, lck: lck_q};

endmodule

// File: hdl/cae_div.sv
// Restoring divider, one quotient bit per cycle: 64-bit dividend by a count divisor.
// Depends on cae_pkg.
`timescale 1ns / 1ps

module cae_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [63:0]             dividend_i,
  input  logic [cae_pkg::CNT_W-1:0] divisor_i,
  output cae_pkg::div_ctl_t       ctl_o,
  output logic [63:0]             quot_o
);
  import cae_pkg::*;

  logic [63:0]      quo_q;
  logic [CNT_W:0]   rem_q;
  logic [CNT_W-1:0] dvs_q;
  logic [6:0]       cnt_q;
  logic             busy_q, done_q;
  logic [CNT_W:0]   trial;

  assign trial = {rem_q[CNT_W-1:0], quo_q[63]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 7'd64;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_q <= trial - {1'b0, dvs_q};
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[62:0], 1'b0};
      end
    end
  end

  assign ctl_o  = '{start: start_i, busy: busy_q, done: done_q};
  assign quot_o = quo_q;

endmodule

// File: hdl/clause_activity_eviction_top.sv
// Top level of the clause activity eviction block: ring of slot cells and its controller.
// Depends on cae_pkg, cae_cell and cae_div.
`timescale 1ns / 1ps

// The block keeps a table of TABLE_DEPTH activity slots held in a ring of cells.
// Input transactions (in_valid_i / in_stall_o, payload in_data_i) carry one action:
// insert, bump, set lock, set increment, run deletion, or query. Every accepted
// transaction yields exactly one result transaction on out_valid_o / out_stall_i.
// The ring rotates one slot per cycle past a single processing head while a pass
// runs (it stands still in idle, during divides and while a result waits), so every
// action takes one full revolution of all TABLE_DEPTH slots. A bump that triggers a
// rescale takes a second revolution. A deletion run takes the first revolution, a
// divide for the threshold, the pass-one revolution, and, when pass two applies,
// another divide and revolution.
// One transaction is worked on at a time; in_stall_o is high while busy.
// The result sits in an output register, so a new transaction is taken while a
// finished result still waits; a stalled result holds until it is taken.
// Reset (rst_ni low, asynchronous) clears all valid and lock bits, the live count,
// and sets the increment to 1.0 in Q32.32. No clearing pass is needed.
module clause_activity_eviction_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  cae_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output cae_pkg::out_t  out_data_o
);
  import cae_pkg::*;

  state_e state_q, state_d;
  in_t    item_q;
  logic [IDX_W-1:0] ptr_q;
  logic [63:0] inc_q, inc_d, total_q, total_d, thr_q, thr_d;
  logic [CNT_W-1:0] live_q, live_d, scanned_q, scanned_d, removed_q, removed_d;
  logic [CNT_W-1:0] second_q, second_d, half_q;
  logic resc_q, resc_d;
  logic cap_vld_q, cap_vld_d, cap_lck_q, cap_lck_d;
  logic [63:0] cap_act_q, cap_act_d;
  out_t out_q;
  logic out_valid_q;

  cell_t cq [TABLE_DEPTH];
  cell_t head, proc;
  logic shift, last, in_range, hit, out_free;

  div_ctl_t div_ctl;
  logic div_start;
  logic [63:0] div_dividend, div_quot;
  logic [CNT_W-1:0] div_divisor;
  logic [64:0] sum;

  // Ring: cell k takes from cell k+1; the last cell takes the processed head.
  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    cell_t din;
    if (k == TABLE_DEPTH - 1) begin : g_tail
      assign din = proc;
    end else begin : g_mid
      assign din = cq[k+1];
    end
    cae_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift),
      .d_i    (din),
      .q_o    (cq[k])
    );
  end

  cae_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .ctl_o     (div_ctl),
    .quot_o    (div_quot)
  );

  assign head     = cq[0];
  assign last     = (ptr_q == IDX_W'(TABLE_DEPTH - 1));
  assign in_range = ({1'b0, item_q.entry} < 7'(TABLE_DEPTH));
  assign hit      = in_range && (item_q.entry == 6'(ptr_q));
  assign shift    = (state_q == ST_OP) || (state_q == ST_RESC) ||
                    (state_q == ST_P1) || (state_q == ST_P2);
  assign out_free = !out_valid_q || !out_stall_i;
  assign div_start    = (state_q == ST_DIV1) || (state_q == ST_DIV2);
  assign div_dividend = (state_q == ST_DIV1) ? inc_q : total_q;
  assign div_divisor  = (state_q == ST_DIV1) ? live_q : scanned_q;

  // Head datapath: work on the slot passing the head and update the counters.
  always_comb begin
    proc      = head;
    inc_d     = inc_q;
    total_d   = total_q;
    thr_d     = thr_q;
    live_d    = live_q;
    scanned_d = scanned_q;
    removed_d = removed_q;
    second_d  = second_q;
    resc_d    = resc_q;
    sum       = '0;
    unique case (state_q)
      ST_IDLE: begin
        // A new transaction clears the per-run counters; set increment acts at once.
        if (in_valid_i) begin
          total_d   = '0;
          scanned_d = '0;
          removed_d = '0;
          second_d  = '0;
          resc_d    = 1'b0;
          if (in_data_i.action == ACT_SETINC) inc_d = in_data_i.value;
        end
      end
      ST_OP: begin
        if (hit) begin
          priority case (item_q.action)
            ACT_INSERT: begin
              proc = '{act: item_q.value, vld: 1'b1, lck: item_q.locked};
              if (!head.vld) live_d = live_q + 7'd1;
            end
            ACT_BUMP: begin
              if (head.vld) begin
                sum = {1'b0, head.act} + {1'b0, inc_q};
                proc.act = sum[64] ? '1 : sum[63:0];
                if (proc.act > LIMIT_VAL) resc_d = 1'b1;
              end
            end
            ACT_LOCK: begin
              if (head.vld) proc.lck = item_q.locked;
            end
            default: ;
          endcase
        end
      end
      ST_RESC: begin
        if (head.vld) proc.act = head.act >> RESCALE_SHIFT;
        if (last) inc_d = inc_q >> RESCALE_SHIFT;
      end
      ST_WAIT1: if (div_ctl.done) thr_d = div_quot;
      ST_WAIT2: if (div_ctl.done) total_d = div_quot;
      ST_P1: begin
        if (head.vld && !head.lck) begin
          sum = {1'b0, total_q} + {1'b0, head.act};
          total_d   = sum[64] ? '1 : sum[63:0];
          scanned_d = scanned_q + 7'd1;
          if (head.act < thr_q) begin
            proc.vld  = 1'b0;
            proc.lck  = 1'b0;
            removed_d = removed_q + 7'd1;
            live_d    = live_q - 7'd1;
          end
        end
      end
      ST_P2: begin
        if (second_q < half_q && head.vld && !head.lck && head.act < total_q) begin
          proc.vld = 1'b0;
          proc.lck = 1'b0;
          second_d = second_q + 7'd1;
          live_d   = live_q - 7'd1;
        end
      end
      default: ;
    endcase
  end

  // The addressed slot's report is refreshed on every revolution as it passes the head.
  always_comb begin
    cap_vld_d = cap_vld_q;
    cap_lck_d = cap_lck_q;
    cap_act_d = cap_act_q;
    if (shift && hit) begin
      cap_vld_d = proc.vld;
      cap_lck_d = proc.vld && proc.lck;
      cap_act_d = proc.vld ? proc.act : '0;
    end else if (state_q == ST_IDLE && in_valid_i) begin
      cap_vld_d = 1'b0;
      cap_lck_d = 1'b0;
      cap_act_d = '0;
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_OP;
      ST_OP: begin
        if (last) begin
          if (resc_d) state_d = ST_RESC;
          else if (item_q.action == ACT_DELETE && live_q != '0) state_d = ST_DIV1;
          else state_d = ST_OUT;
        end
      end
      ST_RESC:  if (last) state_d = ST_OUT;
      ST_DIV1:  state_d = ST_WAIT1;
      ST_WAIT1: if (div_ctl.done) state_d = ST_P1;
      ST_P1: begin
        if (last) state_d = (scanned_d != '0 && half_q != '0) ? ST_DIV2 : ST_OUT;
      end
      ST_DIV2:  state_d = ST_WAIT2;
      ST_WAIT2: if (div_ctl.done) state_d = ST_P2;
      ST_P2:    if (last) state_d = ST_OUT;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ptr_q       <= '0;
      inc_q       <= ONE_Q32;
      live_q      <= '0;
      out_valid_q <= 1'b0;
      resc_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      live_q  <= live_d;
      inc_q   <= inc_d;
      resc_q  <= resc_d;
      if (shift) ptr_q <= last ? '0 : ptr_q + IDX_W'(1);
      if (state_q == ST_OUT && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    total_q   <= total_d;
    thr_q     <= thr_d;
    scanned_q <= scanned_d;
    removed_q <= removed_d;
    second_q  <= second_d;
    cap_vld_q <= cap_vld_d;
    cap_lck_q <= cap_lck_d;
    cap_act_q <= cap_act_d;
    if (state_q == ST_IDLE && in_valid_i) begin
      item_q <= in_data_i;
      half_q <= live_q >> 1;
    end
    if (state_q == ST_OUT && out_free) begin
      out_q.valid_res     <= cap_vld_q;
      out_q.activity      <= cap_act_q;
      out_q.lock_state    <= cap_lck_q;
      out_q.rescaled      <= resc_q;
      out_q.deleted_count <= (item_q.action == ACT_DELETE) ? removed_q + second_q : '0;
      out_q.live_count    <= live_q;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: hdl/cae_checker.sv
// Port-level checker for clause_activity_eviction_top, attached by a bind statement.
// Depends on cae_pkg and the top level.
`timescale 1ns / 1ps

module cae_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input cae_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input cae_pkg::out_t out_data_o
);
  import cae_pkg::*;

  // A transaction that is taken keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block took a second transaction right after the first");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

  // A slot reported as not live shows no activity and no lock.
  a_dead_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.valid_res) |->
      (out_data_o.activity == '0 && !out_data_o.lock_state))
    else $error("dead slot reported with data");

  // Counts stay within the table.
  a_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.live_count <= 7'(TABLE_DEPTH) &&
                     out_data_o.deleted_count <= 7'(TABLE_DEPTH)))
    else $error("count beyond table depth");

endmodule

bind clause_activity_eviction_top cae_checker u_cae_checker (.*);
